>>> sv/rs485_frame_receiver_core_macros.svh
// assertion helpers used by the parser module
`ifndef RS485_FRAME_RECEIVER_CORE_MACROS_SVH
`define RS485_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define RS485FR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define RS485FR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/rs485fr_pkg.sv
`default_nettype none

package rs485fr_pkg;

	// framing bytes
	localparam logic [7:0] SOH_BYTE = 8'h01;
	localparam logic [7:0] STX_BYTE = 8'h02;
	localparam logic [7:0] ETX_BYTE = 8'h03;
	localparam logic [7:0] EOT_BYTE = 8'h04;

	// broadcast destination
	localparam logic [7:0] BROADCAST_ADDR = 8'h00;

	// header window depth (bytes held before the stx)
	localparam int WINDOW_DEPTH = 6;

	// width of each reported count
	localparam int CNT_OUT_W = 16;

	// packed output beat width
	localparam int OUT_TDATA_W = 88;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (6 * 8 + 1 + 2 * CNT_OUT_W);

	// configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_STATION = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_PING_TYPE     = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_DATA,
		PH_ETX,
		PH_SUM,
		PH_EOT
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_GOOD,
		KIND_BAD_SUM,
		KIND_MALFORMED
	} kind_t;

	typedef struct packed {
		logic [7:0] local_station;
		logic [7:0] ping_type_code;
	} cfg_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           sender;
		logic [7:0]           destination;
		logic [7:0]           command;
		logic [7:0]           payload_length;
		logic [7:0]           packet_kind;
		logic [7:0]           data_byte;
		logic                 ping_for_us;
		logic [CNT_OUT_W-1:0] malformed_count;
		logic [CNT_OUT_W-1:0] checksum_error_count;
	} result_t;

endpackage

`default_nettype wire

>>> sv/rs485_frame_receiver_core.sv
// framed packet receiver for a half-duplex serial bus
// s_axis carries one received byte per beat in tdata[7:0]
// while hunting, a packet starts at soh, destination (local station or
// broadcast 0), sender, command, length, type, stx; the payload bytes then
// each come out on m_axis as a data beat (tuser kind 0), and the packet end
// (etx, checksum, eot) gives one beat: good (1), bad checksum (2) or
// malformed (3); ping_for_us marks a good ping aimed at this station
// cfg writes local_station (index 0) and ping_type_code (index 1); write
// only while no packet is in flight; cfg_ready is always high
// a byte accepted on s_axis passes through the input stage and then the
// result register before its result shows on m_axis
// throughput: one byte per cycle with the result side ready
// when m_axis stalls the result register holds, the input stage fills and
// s_axis_tready falls once both are occupied; nothing is dropped
// reset clears the packet state, window, counts and registers to zero and
// the block hunts for a header; no clearing pass is needed
`default_nettype none

module rs485_frame_receiver_core #(
	parameter int COUNTER_WIDTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // rx_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	// sender, destination, command, payload_length, packet_kind, data_byte,
	// ping_for_us, malformed_count, checksum_error_count, zero pad
	output logic [rs485fr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]      m_axis_tuser,   // kind
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [rs485fr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	rs485fr_pkg::cfg_t    cfg_q;
	rs485fr_pkg::result_t result;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 advance;
	logic                 slot_free;
	logic                 emit;

	// register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rs485fr_pkg::REG_LOCAL_STATION: cfg_q.local_station  <= cfg_data;
				rs485fr_pkg::REG_PING_TYPE:     cfg_q.ping_type_code <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// a held byte is processed when the result register has room
	assign advance = valid_s1 && slot_free;

	rs485fr_in_reg u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.byte_s1       (byte_s1)
	);

	rs485fr_parser #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.emit    (emit),
		.result  (result)
	);

	rs485fr_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (emit),
		.result        (result),
		.slot_free     (slot_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

>>> sv/rs485fr_in_reg.sv
`default_nettype none

module rs485fr_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // rx_byte
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// room whenever the held beat is empty or moves on this cycle
	assign s_axis_tready = !valid_s1 || advance;

	// occupancy of the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// byte capture
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

endmodule

`default_nettype wire

>>> sv/rs485fr_parser.sv
`default_nettype none

`include "rs485_frame_receiver_core_macros.svh"

module rs485fr_parser #(
	parameter int COUNTER_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       rx_byte,
	input  wire rs485fr_pkg::cfg_t cfg,
	output logic                  emit,
	output rs485fr_pkg::result_t  result
);

	rs485fr_pkg::phase_t phase_q, phase_d;

	logic [7:0] win_q [rs485fr_pkg::WINDOW_DEPTH];
	logic [7:0] idx_q;
	logic [7:0] dest_q;
	logic [7:0] send_q;
	logic [7:0] cmd_q;
	logic [7:0] len_q;
	logic [7:0] type_q;
	logic [7:0] sum_q;
	logic [7:0] recv_q;
	logic [COUNTER_WIDTH-1:0] malf_q;
	logic [COUNTER_WIDTH-1:0] bad_q;

	logic       hdr_match;
	logic       etx_ok;
	logic       eot_ok;
	logic       sum_ok;
	logic [7:0] idx_inc;
	logic       last_data;
	logic [7:0] hdr_sum;

	rs485fr_pkg::kind_t kind;
	logic       [7:0]   data_out;
	logic               ping;
	logic               load_hdr;
	logic               add_data;
	logic               take_sum;
	logic               end_pkt;
	logic               bump_malf;
	logic               bump_bad;

	logic [COUNTER_WIDTH-1:0]                      malf_next;
	logic [COUNTER_WIDTH-1:0]                      bad_next;
	logic [COUNTER_WIDTH+rs485fr_pkg::CNT_OUT_W-1:0] malf_ext;
	logic [COUNTER_WIDTH+rs485fr_pkg::CNT_OUT_W-1:0] bad_ext;

	// byte checks
	assign hdr_match = (rx_byte == rs485fr_pkg::STX_BYTE)
		&& (win_q[0] == rs485fr_pkg::SOH_BYTE)
		&& ((win_q[1] == cfg.local_station) || (win_q[1] == rs485fr_pkg::BROADCAST_ADDR));
	assign etx_ok    = (rx_byte == rs485fr_pkg::ETX_BYTE);
	assign eot_ok    = (rx_byte == rs485fr_pkg::EOT_BYTE);
	assign sum_ok    = (recv_q == sum_q);
	assign idx_inc   = idx_q + 8'd1;
	assign last_data = (idx_inc == len_q);
	assign hdr_sum   = win_q[1] + win_q[2] + win_q[3] + win_q[4] + win_q[5];

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (step) begin
			case (phase_q)
				rs485fr_pkg::PH_HUNT: begin
					if (hdr_match) phase_d = rs485fr_pkg::PH_DATA;
				end
				rs485fr_pkg::PH_DATA: begin
					if (len_q == 8'd0) begin
						phase_d = etx_ok ? rs485fr_pkg::PH_SUM : rs485fr_pkg::PH_HUNT;
					end else if (last_data) begin
						phase_d = rs485fr_pkg::PH_ETX;
					end
				end
				rs485fr_pkg::PH_ETX: begin
					phase_d = etx_ok ? rs485fr_pkg::PH_SUM : rs485fr_pkg::PH_HUNT;
				end
				rs485fr_pkg::PH_SUM: begin
					phase_d = rs485fr_pkg::PH_EOT;
				end
				rs485fr_pkg::PH_EOT: begin
					phase_d = rs485fr_pkg::PH_HUNT;
				end
				default: begin
					phase_d = rs485fr_pkg::PH_HUNT;
				end
			endcase
		end
	end

	// per-byte actions and result kind
	always_comb begin
		emit      = 1'b0;
		kind      = rs485fr_pkg::KIND_DATA;
		data_out  = 8'd0;
		ping      = 1'b0;
		load_hdr  = 1'b0;
		add_data  = 1'b0;
		take_sum  = 1'b0;
		end_pkt   = 1'b0;
		bump_malf = 1'b0;
		bump_bad  = 1'b0;
		if (step) begin
			case (phase_q)
				rs485fr_pkg::PH_HUNT: begin
					load_hdr = hdr_match;
				end
				rs485fr_pkg::PH_DATA: begin
					if (len_q == 8'd0) begin
						if (!etx_ok) begin
							emit      = 1'b1;
							kind      = rs485fr_pkg::KIND_MALFORMED;
							bump_malf = 1'b1;
							end_pkt   = 1'b1;
						end
					end else begin
						emit     = 1'b1;
						kind     = rs485fr_pkg::KIND_DATA;
						data_out = rx_byte;
						add_data = 1'b1;
					end
				end
				rs485fr_pkg::PH_ETX: begin
					if (!etx_ok) begin
						emit      = 1'b1;
						kind      = rs485fr_pkg::KIND_MALFORMED;
						bump_malf = 1'b1;
						end_pkt   = 1'b1;
					end
				end
				rs485fr_pkg::PH_SUM: begin
					take_sum = 1'b1;
				end
				rs485fr_pkg::PH_EOT: begin
					emit    = 1'b1;
					end_pkt = 1'b1;
					if (!eot_ok) begin
						kind      = rs485fr_pkg::KIND_MALFORMED;
						bump_malf = 1'b1;
					end else if (sum_ok) begin
						kind = rs485fr_pkg::KIND_GOOD;
						ping = (type_q == cfg.ping_type_code) && (dest_q == cfg.local_station);
					end else begin
						kind     = rs485fr_pkg::KIND_BAD_SUM;
						bump_bad = 1'b1;
					end
				end
				default: begin
					end_pkt = 1'b1;
				end
			endcase
		end
	end

	// counts after this byte
	assign malf_next = malf_q + COUNTER_WIDTH'(bump_malf);
	assign bad_next  = bad_q + COUNTER_WIDTH'(bump_bad);
	assign malf_ext  = {{rs485fr_pkg::CNT_OUT_W{1'b0}}, malf_next};
	assign bad_ext   = {{rs485fr_pkg::CNT_OUT_W{1'b0}}, bad_next};

	// result assembly from the header as it stood before this byte
	always_comb begin
		result.kind                 = kind;
		result.sender               = send_q;
		result.destination          = dest_q;
		result.command              = cmd_q;
		result.payload_length       = len_q;
		result.packet_kind          = type_q;
		result.data_byte            = data_out;
		result.ping_for_us          = ping;
		result.malformed_count      = malf_ext[rs485fr_pkg::CNT_OUT_W-1:0];
		result.checksum_error_count = bad_ext[rs485fr_pkg::CNT_OUT_W-1:0];
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rs485fr_pkg::PH_HUNT;
			for (int i = 0; i < rs485fr_pkg::WINDOW_DEPTH; i++) win_q[i] <= 8'd0;
			idx_q   <= 8'd0;
			dest_q  <= 8'd0;
			send_q  <= 8'd0;
			cmd_q   <= 8'd0;
			len_q   <= 8'd0;
			type_q  <= 8'd0;
			sum_q   <= 8'd0;
			recv_q  <= 8'd0;
			malf_q  <= '0;
			bad_q   <= '0;
		end else begin
			phase_q <= phase_d;
			malf_q  <= malf_next;
			bad_q   <= bad_next;
			// window only slides while hunting
			if (step && (phase_q == rs485fr_pkg::PH_HUNT)) begin
				for (int i = 0; i < rs485fr_pkg::WINDOW_DEPTH - 1; i++) win_q[i] <= win_q[i+1];
				win_q[rs485fr_pkg::WINDOW_DEPTH-1] <= rx_byte;
			end
			if (load_hdr) begin
				dest_q <= win_q[1];
				send_q <= win_q[2];
				cmd_q  <= win_q[3];
				len_q  <= win_q[4];
				type_q <= win_q[5];
				sum_q  <= hdr_sum;
				idx_q  <= 8'd0;
			end
			if (add_data) begin
				sum_q <= sum_q + rx_byte;
				idx_q <= last_data ? 8'd0 : idx_inc;
			end
			if (take_sum) begin
				recv_q <= rx_byte;
			end
			if (end_pkt) begin
				dest_q <= 8'd0;
				send_q <= 8'd0;
				cmd_q  <= 8'd0;
				len_q  <= 8'd0;
				type_q <= 8'd0;
				sum_q  <= 8'd0;
				recv_q <= 8'd0;
				idx_q  <= 8'd0;
			end
		end
	end

	// checks
	`RS485FR_ASSERT_NEXT(a_sum_then_eot, clk, arst_n,
		step && (phase_q == rs485fr_pkg::PH_SUM), phase_q == rs485fr_pkg::PH_EOT,
		"checksum byte not followed by eot phase")
	`RS485FR_ASSERT_NOW(a_idx_in_range, clk, arst_n,
		(phase_q == rs485fr_pkg::PH_DATA) && (len_q != 8'd0), idx_q < len_q,
		"payload index ran past declared length")
	`RS485FR_ASSERT_NEXT(a_malf_count, clk, arst_n,
		emit && (kind == rs485fr_pkg::KIND_MALFORMED),
		(malf_q == $past(malf_q) + 1'b1) && (phase_q == rs485fr_pkg::PH_HUNT),
		"malformed packet not counted or not back to hunting")

endmodule

`default_nettype wire

>>> sv/rs485fr_out_reg.sv
`default_nettype none

module rs485fr_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire rs485fr_pkg::result_t result,
	output logic                      slot_free,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// sender, destination, command, payload_length, packet_kind, data_byte,
	// ping_for_us, malformed_count, checksum_error_count, zero pad
	output logic [rs485fr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]                m_axis_tuser  // kind
);

	logic                 out_valid_q;
	rs485fr_pkg::result_t res_q;

	// a new result may land when the register is empty or being drained
	assign slot_free = !out_valid_q || m_axis_tready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	// beat packing, first field lowest
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tdata  = {
		{rs485fr_pkg::OUT_PAD_W{1'b0}},
		res_q.checksum_error_count,
		res_q.malformed_count,
		res_q.ping_for_us,
		res_q.data_byte,
		res_q.packet_kind,
		res_q.payload_length,
		res_q.command,
		res_q.destination,
		res_q.sender
	};

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int QUIET_LIMIT = 1000;

	typedef enum {
		FAULT_NONE,
		FAULT_SUM,
		FAULT_ETX,
		FAULT_EOT
	} fault_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [7:0]                          s_axis_tdata = 8'h00;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [rs485fr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]                          m_axis_tuser;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [rs485fr_pkg::CFG_INDEX_W-1:0] cfg_index = rs485fr_pkg::REG_LOCAL_STATION;
	logic [7:0]                          cfg_data = 8'h00;

	rs485_frame_receiver_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// frame decoder state, mirrors the block
	rs485fr_pkg::phase_t ph = rs485fr_pkg::PH_HUNT;
	logic [7:0]  win [6] = '{default: 8'h00};
	logic [7:0]  idx = 8'h00;
	logic [7:0]  h_dst = 8'h00, h_src = 8'h00, h_cmd = 8'h00, h_len = 8'h00, h_type = 8'h00;
	logic [7:0]  run_sum = 8'h00, rcv_sum = 8'h00;
	logic [15:0] malformed_cnt = 16'h0000, bad_sum_cnt = 16'h0000;
	logic [7:0]  station_reg = 8'h00, ping_type_reg = 8'h00;

	rs485fr_pkg::result_t expected_beats [$];

	bit steady = 1'b0;
	int errors = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int configs = 0;
	int beats_by_kind [4] = '{default: 0};
	int pings_seen = 0;

	// build a result beat from the current header
	function automatic rs485fr_pkg::result_t make_beat(rs485fr_pkg::kind_t k,
			logic [7:0] data, logic ping);
		rs485fr_pkg::result_t r;
		r.kind                 = k;
		r.sender               = h_src;
		r.destination          = h_dst;
		r.command              = h_cmd;
		r.payload_length       = h_len;
		r.packet_kind          = h_type;
		r.data_byte            = data;
		r.ping_for_us          = ping;
		r.malformed_count      = malformed_cnt;
		r.checksum_error_count = bad_sum_cnt;
		return r;
	endfunction

	task automatic close_packet();
		ph = rs485fr_pkg::PH_HUNT;
		idx = 8'h00;
		h_dst = 8'h00;
		h_src = 8'h00;
		h_cmd = 8'h00;
		h_len = 8'h00;
		h_type = 8'h00;
		run_sum = 8'h00;
		rcv_sum = 8'h00;
	endtask

	task automatic flag_malformed();
		malformed_cnt = malformed_cnt + 16'd1;
		expected_beats.push_back(make_beat(rs485fr_pkg::KIND_MALFORMED, 8'h00, 1'b0));
		close_packet();
	endtask

	// advance the frame decoder by one received byte
	task automatic decode_byte(input logic [7:0] b);
		int i;
		case (ph)
			rs485fr_pkg::PH_HUNT: begin
				if (b == rs485fr_pkg::STX_BYTE && win[0] == rs485fr_pkg::SOH_BYTE &&
						(win[1] == station_reg || win[1] == rs485fr_pkg::BROADCAST_ADDR)) begin
					h_dst = win[1];
					h_src = win[2];
					h_cmd = win[3];
					h_len = win[4];
					h_type = win[5];
					run_sum = h_dst + h_src + h_cmd + h_len + h_type;
					idx = 8'h00;
					ph = rs485fr_pkg::PH_DATA;
				end
				for (i = 0; i < 5; i++)
					win[i] = win[i+1];
				win[5] = b;
			end
			rs485fr_pkg::PH_DATA: begin
				if (h_len == 8'h00) begin
					if (b != rs485fr_pkg::ETX_BYTE)
						flag_malformed();
					else
						ph = rs485fr_pkg::PH_SUM;
				end else begin
					run_sum = run_sum + b;
					idx = idx + 8'd1;
					expected_beats.push_back(make_beat(rs485fr_pkg::KIND_DATA, b, 1'b0));
					if (idx == h_len) begin
						idx = 8'h00;
						ph = rs485fr_pkg::PH_ETX;
					end
				end
			end
			rs485fr_pkg::PH_ETX: begin
				if (b != rs485fr_pkg::ETX_BYTE)
					flag_malformed();
				else
					ph = rs485fr_pkg::PH_SUM;
			end
			rs485fr_pkg::PH_SUM: begin
				rcv_sum = b;
				ph = rs485fr_pkg::PH_EOT;
			end
			rs485fr_pkg::PH_EOT: begin
				if (b != rs485fr_pkg::EOT_BYTE) begin
					flag_malformed();
				end else begin
					if (rcv_sum == run_sum) begin
						expected_beats.push_back(make_beat(rs485fr_pkg::KIND_GOOD, 8'h00,
							h_type == ping_type_reg && h_dst == station_reg));
					end else begin
						bad_sum_cnt = bad_sum_cnt + 16'd1;
						expected_beats.push_back(make_beat(rs485fr_pkg::KIND_BAD_SUM, 8'h00,
							1'b0));
					end
					close_packet();
				end
			end
			default: close_packet();
		endcase
	endtask

	// one byte beat on s_axis, after a random gap
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		decode_byte(b);
		bytes_sent++;
	endtask

	function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
		logic [7:0] b;
		do b = 8'($urandom); while (b == avoid);
		return b;
	endfunction

	// whole frame, fill < 0 gives random payload
	task automatic send_frame(input logic [7:0] dst, src, cmd, typ, input int len,
			input int fill, input fault_t fault);
		logic [7:0] sum, b;
		int i;
		sum = dst + src + cmd + len[7:0] + typ;
		send_byte(rs485fr_pkg::SOH_BYTE);
		send_byte(dst);
		send_byte(src);
		send_byte(cmd);
		send_byte(len[7:0]);
		send_byte(typ);
		send_byte(rs485fr_pkg::STX_BYTE);
		for (i = 0; i < len; i++) begin
			b = (fill < 0) ? 8'($urandom) : fill[7:0];
			sum = sum + b;
			send_byte(b);
		end
		send_byte(fault == FAULT_ETX ? byte_other_than(rs485fr_pkg::ETX_BYTE) :
			rs485fr_pkg::ETX_BYTE);
		if (fault == FAULT_SUM)
			sum = sum + 8'($urandom_range(1, 255));
		send_byte(sum);
		send_byte(fault == FAULT_EOT ? byte_other_than(rs485fr_pkg::EOT_BYTE) :
			rs485fr_pkg::EOT_BYTE);
		frames_sent++;
	endtask

	// close any open packet, drain the results and let the pipeline empty
	task automatic settle();
		while (ph != rs485fr_pkg::PH_HUNT)
			send_byte(8'h00);
		s_axis_tvalid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers, back to back on the cfg channel
	task automatic write_regs(input logic [7:0] station, ptype);
		cfg_valid <= 1'b1;
		cfg_index <= rs485fr_pkg::REG_LOCAL_STATION;
		cfg_data <= station;
		do @(posedge clk); while (!cfg_ready);
		station_reg = station;
		cfg_index <= rs485fr_pkg::REG_PING_TYPE;
		cfg_data <= ptype;
		do @(posedge clk); while (!cfg_ready);
		ping_type_reg = ptype;
		cfg_valid <= 1'b0;
		configs++;
	endtask

	task automatic test_directed();
		write_regs(8'h5A, 8'h7E);
		// good frames, payload extremes
		send_frame(8'h5A, 8'h00, 8'hFF, 8'h00, 2, 8'h00, FAULT_NONE);
		send_frame(8'h5A, 8'hFF, 8'h00, 8'hFF, 1, 8'hFF, FAULT_NONE);
		// broadcast ping is good but needs no reply
		send_frame(rs485fr_pkg::BROADCAST_ADDR, 8'h12, 8'h34, 8'h7E, 3, 8'hFF, FAULT_NONE);
		// ping aimed at this station, zero length
		send_frame(8'h5A, 8'h21, 8'h43, 8'h7E, 0, 0, FAULT_NONE);
		// zero length without etx
		send_frame(8'h5A, 8'h21, 8'h43, 8'h10, 0, 0, FAULT_ETX);
		// payload then no etx
		send_frame(8'h5A, 8'h66, 8'h77, 8'h10, 1, -1, FAULT_ETX);
		// missing eot
		send_frame(rs485fr_pkg::BROADCAST_ADDR, 8'h66, 8'h77, 8'h7E, 2, -1, FAULT_EOT);
		// checksum error
		send_frame(8'h5A, 8'h80, 8'h01, 8'h20, 4, -1, FAULT_SUM);
		// other station, ignored
		send_frame(8'h33, 8'h01, 8'h02, 8'h7E, 2, 8'h00, FAULT_NONE);
		settle();
		// the header window survives a packet end: a lone stx reopens a frame
		// from the old header bytes (destination 0, sender 11, length 0, type 02)
		write_regs(8'h01, 8'h02);
		send_frame(8'h01, 8'h00, 8'h11, 8'h00, 0, 0, FAULT_NONE);
		send_byte(rs485fr_pkg::STX_BYTE);
		send_byte(rs485fr_pkg::ETX_BYTE);
		send_byte(8'h13);
		send_byte(rs485fr_pkg::EOT_BYTE);
		send_frame(rs485fr_pkg::BROADCAST_ADDR, 8'h09, 8'h08, 8'h02, 1, -1, FAULT_NONE);
	endtask

	// mostly well-formed frames with random content, some faults and noise
	task automatic test_random(input logic [7:0] station, ptype, input int budget,
			input bit no_gaps);
		int first, r, len, n, i;
		logic [7:0] dst, typ;
		fault_t fault;
		settle();
		write_regs(station, ptype);
		steady = no_gaps;
		first = bytes_sent;
		while (bytes_sent - first < budget) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				// noise, biased towards the framing bytes
				n = $urandom_range(1, 10);
				for (i = 0; i < n; i++)
					send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom));
			end else begin
				r = $urandom_range(0, 9);
				dst = (r < 4) ? station_reg : (r < 8) ? rs485fr_pkg::BROADCAST_ADDR :
					8'($urandom);
				typ = $urandom_range(0, 1) ? ping_type_reg : 8'($urandom);
				r = $urandom_range(0, 99);
				len = (r < 15) ? 0 : (r < 80) ? $urandom_range(1, 8) :
					(r < 98) ? $urandom_range(9, 40) : $urandom_range(100, 255);
				case ($urandom_range(0, 9))
					0: fault = FAULT_SUM;
					1: fault = FAULT_ETX;
					2: fault = FAULT_EOT;
					default: fault = FAULT_NONE;
				endcase
				send_frame(dst, 8'($urandom), 8'($urandom), typ, len, -1, fault);
			end
		end
		steady = 1'b0;
	endtask

	task automatic check_field(input string name, input int unsigned want, got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// result side: random stall before each beat
	initial begin : result_sink
		int stall;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin : beat_check
		rs485fr_pkg::result_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind                 = rs485fr_pkg::kind_t'(m_axis_tuser);
			got.sender               = m_axis_tdata[7:0];
			got.destination          = m_axis_tdata[15:8];
			got.command              = m_axis_tdata[23:16];
			got.payload_length       = m_axis_tdata[31:24];
			got.packet_kind          = m_axis_tdata[39:32];
			got.data_byte            = m_axis_tdata[47:40];
			got.ping_for_us          = m_axis_tdata[48];
			got.malformed_count      = m_axis_tdata[64:49];
			got.checksum_error_count = m_axis_tdata[80:65];
			beats_by_kind[m_axis_tuser]++;
			if (got.kind == rs485fr_pkg::KIND_GOOD && got.ping_for_us)
				pings_seen++;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got kind %0d data %0h",
					$time, got.kind, got.data_byte);
				errors++;
			end else begin
				want = expected_beats.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("sender", want.sender, got.sender);
				check_field("destination", want.destination, got.destination);
				check_field("command", want.command, got.command);
				check_field("payload_length", want.payload_length, got.payload_length);
				check_field("packet_kind", want.packet_kind, got.packet_kind);
				check_field("data_byte", want.data_byte, got.data_byte);
				check_field("ping_for_us", want.ping_for_us, got.ping_for_us);
				check_field("malformed_count", want.malformed_count, got.malformed_count);
				check_field("checksum_error_count", want.checksum_error_count,
					got.checksum_error_count);
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin : watchdog
		int quiet;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d beats outstanding",
				$time, QUIET_LIMIT, expected_beats.size());
			$display("rs485_frame_receiver_core regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(8'h00, 8'h00, 120, 1'b0);
		test_random(8'hFF, 8'hFF, 120, 1'b1);
		test_random(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)), 120, 1'b0);
		test_random(8'h5A, 8'h7E, 120, 1'b0);
		settle();
		repeat (10) @(posedge clk);
		$display("sent %0d bytes in %0d frames plus noise under %0d register settings",
			bytes_sent, frames_sent, configs);
		$display("checked %0d payload beats, %0d good (%0d pings), %0d bad sum, %0d malformed",
			beats_by_kind[rs485fr_pkg::KIND_DATA], beats_by_kind[rs485fr_pkg::KIND_GOOD],
			pings_seen, beats_by_kind[rs485fr_pkg::KIND_BAD_SUM],
			beats_by_kind[rs485fr_pkg::KIND_MALFORMED]);
		if (errors == 0)
			$display("rs485_frame_receiver_core regression: pass");
		else
			$display("rs485_frame_receiver_core regression: fail");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/rs485fr_pkg.sv
sv/rs485fr_in_reg.sv
sv/rs485fr_parser.sv
sv/rs485fr_out_reg.sv
sv/rs485_frame_receiver_core.sv
dv/tb.sv
